[sv/pmd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and constants of the PDM decimator with sample FIFO.
// ----------------------------------------------------------------------------
package pmd_pkg;

  // Request type codes on req_type.
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_WRITE  = 2'd2;

  // Register byte offsets on the bus.
  localparam logic [7:0] ADDR_CTRL   = 8'd0;
  localparam logic [7:0] ADDR_STATUS = 8'd4;
  localparam logic [7:0] ADDR_DATA   = 8'd8;
  localparam logic [7:0] ADDR_WMARK  = 8'd12;
  localparam logic [7:0] ADDR_CLEAR  = 8'd16;

  // The only legal bus access length in bytes.
  localparam logic [7:0] BUS_LEN = 8'd4;

  // Configuration register indexes.
  localparam logic CFG_CONTROL = 1'b0;
  localparam logic CFG_WMARK   = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [31:0] CONTROL_RESET = 32'h0000_4000;
  localparam logic [7:0]  WMARK_RESET   = 8'd16;

  // A decimation factor of zero stands for this factor.
  localparam logic [7:0] FACTOR_DEFAULT = 8'd64;

  // Depths of the internal queues.
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 4;

  typedef enum logic [1:0] {
    RESP_OK    = 2'd0,
    RESP_BURST = 2'd1,
    RESP_ADDR  = 2'd2
  } resp_t;

  typedef enum logic [3:0] {
    OP_NOP,       // unknown request type: answers ok, no effect
    OP_ERR,       // bus access error, code carried with the command
    OP_SAMPLE,    // PDM density sample
    OP_RD_CTRL,
    OP_RD_STATUS,
    OP_RD_DATA,
    OP_RD_WMARK,
    OP_WR_REG,    // write to a register owned by the configuration port
    OP_WR_CLEAR   // interrupt flag clear
  } op_t;

  typedef struct packed {
    op_t         op;
    resp_t       code;
    logic [1:0]  clr;
    logic [7:0]  density;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    resp_t       code;
    logic        irq;
  } result_t;

endpackage
`default_nettype wire

[sv/pdm_mic_decimator_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdm_mic_decimator_fifo
// PDM microphone front end with an integrate-and-dump decimator and a sample
// FIFO behind a small register bus.
// ----------------------------------------------------------------------------
// Every item is a PDM density sample, a bus read, a bus write or an unknown
// request type, and every item produces exactly one result item (read data,
// response code and the interrupt level after the item). The block sustains
// one item per clock while the result queue has room: the front end
// classifies an item in the cycle it is pushed and places the command in a
// two-entry queue; the back end executes one command per clock (the
// integrator add, decimation compare, sample FIFO update and flag logic
// form the loop that sets this rate) and forms the result in the following
// cycle, after the registered read of the sample memory. A result passes
// through the command queue, the back end's result stage and the four-entry
// result queue before it can be popped, and the result queue lets the source
// keep pushing while results wait to be popped. full rises only when the
// result side has stalled long enough to fill both queues. The sample
// memory holds FIFO_DEPTH words and needs no clearing pass after reset;
// a pop of an empty FIFO returns zero without touching it. The control and
// watermark registers are written through the configuration channel, which
// is always ready; bus writes to those offsets are acknowledged but leave
// the registers alone.
// ----------------------------------------------------------------------------
module pdm_mic_decimator_fifo
  import pmd_pkg::*;
#(
  parameter int FIFO_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Item input.
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  address,
  input  wire logic [31:0] write_data,
  input  wire logic [7:0]  access_length,
  input  wire logic [7:0]  pdm_density,
  // Result output.
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      read_data,
  output logic [1:0]       response_code,
  output logic             irq_level,
  // Configuration channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int RCW = $clog2(RESQ_DEPTH + 1);
  localparam int CQW = $clog2(CMDQ_DEPTH + 1);

  logic [31:0]    control_word;
  logic [7:0]     watermark_level;

  cmd_t           front_cmd;
  cmd_t           cmdq_out;
  logic           cmdq_empty;
  logic           cmdq_pop;
  logic [CQW-1:0] cmdq_count;

  logic           res_push;
  result_t        res_in;
  result_t        res_out;
  logic           res_full;
  logic [RCW-1:0] res_count;
  logic           room;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_word    <= CONTROL_RESET;
      watermark_level <= WMARK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CONTROL: control_word    <= cfg_data;
        CFG_WMARK:   watermark_level <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  pmd_front u_front (
    .req_type      (req_type),
    .address       (address),
    .write_data    (write_data),
    .access_length (access_length),
    .pdm_density   (pdm_density),
    .cmd           (front_cmd)
  );

  pmd_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_cmd),
    .full  (full),
    .pop   (cmdq_pop),
    .rdata (cmdq_out),
    .empty (cmdq_empty),
    .count (cmdq_count)
  );

  // A command may start only if its result is sure to find a slot, counting
  // the one still in the back end's result stage.
  assign room = ((RCW + 1)'(res_count) + (RCW + 1)'(res_push)) < (RCW + 1)'(RESQ_DEPTH);

  pmd_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (!cmdq_empty),
    .cmd             (cmdq_out),
    .cmd_pop         (cmdq_pop),
    .room            (room),
    .control_word    (control_word),
    .watermark_level (watermark_level),
    .res_push        (res_push),
    .res_data        (res_in)
  );

  pmd_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty),
    .count (res_count)
  );

  assign read_data     = res_out.read_data;
  assign response_code = res_out.code;
  assign irq_level     = res_out.irq;

  a_no_result_drop: assert property (@(posedge clk) disable iff (rst)
    !(res_push && res_full))
    else $error("result pushed into a full result queue");

  a_cmdq_bound: assert property (@(posedge clk) disable iff (rst)
    cmdq_count <= CQW'(CMDQ_DEPTH))
    else $error("command queue holds more than its depth");

endmodule
`default_nettype wire

[sv/pmd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_queue
// Small register queue with push/full and pop/empty, plus a fill count.
// ----------------------------------------------------------------------------
module pmd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic [WIDTH-1:0]             wdata,
  output logic                              full,
  input  wire logic                         pop,
  output logic [WIDTH-1:0]                  rdata,
  output logic                              empty,
  output logic [$clog2(DEPTH+1)-1:0]        count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    wr_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

[sv/pmd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_front
// Classifies an incoming item into a command for the back end.
// ----------------------------------------------------------------------------
module pmd_front
  import pmd_pkg::*;
(
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  address,
  input  wire logic [31:0] write_data,
  input  wire logic [7:0]  access_length,
  input  wire logic [7:0]  pdm_density,
  output cmd_t             cmd
);

  always_comb begin
    cmd.op      = OP_NOP;
    cmd.code    = RESP_OK;
    cmd.clr     = write_data[1:0];
    cmd.density = pdm_density;
    priority if (req_type == REQ_SAMPLE) begin
      cmd.op = OP_SAMPLE;
    end else if (req_type != REQ_READ && req_type != REQ_WRITE) begin
      cmd.op = OP_NOP;
    end else if (access_length != BUS_LEN) begin
      cmd.op   = OP_ERR;
      cmd.code = RESP_BURST;
    end else if (req_type == REQ_READ) begin
      unique case (address)
        ADDR_CTRL:   cmd.op = OP_RD_CTRL;
        ADDR_STATUS: cmd.op = OP_RD_STATUS;
        ADDR_DATA:   cmd.op = OP_RD_DATA;
        ADDR_WMARK:  cmd.op = OP_RD_WMARK;
        default: begin
          cmd.op   = OP_ERR;
          cmd.code = RESP_ADDR;
        end
      endcase
    end else begin
      unique case (address)
        ADDR_CTRL, ADDR_WMARK: cmd.op = OP_WR_REG;
        ADDR_CLEAR:            cmd.op = OP_WR_CLEAR;
        default: begin
          cmd.op   = OP_ERR;
          cmd.code = RESP_ADDR;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/pmd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmd_back
// Executes commands: integrator, decimator, sample FIFO, flags and
// interrupt. Two stages: update state and read the sample memory, then
// form the result.
// ----------------------------------------------------------------------------
module pmd_back
  import pmd_pkg::*;
#(
  parameter int FIFO_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_pop,
  input  wire logic        room,
  input  wire logic [31:0] control_word,
  input  wire logic [7:0]  watermark_level,
  output logic             res_push,
  output result_t          res_data
);

  localparam int AW  = $clog2(FIFO_DEPTH);
  localparam int FW  = $clog2(FIFO_DEPTH + 1);
  localparam int CMW = (FW > 8) ? FW : 8;

  // Architectural state.
  logic [31:0]   running_sum;
  logic [31:0]   previous_sum;
  logic [7:0]    decimation_count;
  logic [AW-1:0] read_pointer;
  logic [AW-1:0] write_pointer;
  logic [FW-1:0] fill_count;
  logic          overrun_bit;
  logic          watermark_bit;
  logic          irq_state;
  logic [31:0]   sample_store [FIFO_DEPTH];

  // Result stage.
  logic          b_valid;
  logic [31:0]   b_rdata;
  logic          b_use_mem;
  resp_t         b_code;
  logic          b_irq;
  logic [31:0]   mem_q;

  // Next values.
  logic [31:0]   running_sum_next;
  logic [31:0]   previous_sum_next;
  logic [7:0]    decimation_count_next;
  logic [AW-1:0] read_pointer_next;
  logic [AW-1:0] write_pointer_next;
  logic [FW-1:0] fill_count_next;
  logic          overrun_bit_next;
  logic          watermark_bit_next;
  logic          irq_state_next;

  logic          exec;
  logic          eval;
  logic          mem_we;
  logic          mem_re;
  logic [7:0]    factor;
  logic [31:0]   sum_inc;
  logic [7:0]    cnt_inc;
  logic [31:0]   diff;
  logic [31:0]   rdata;
  logic          use_mem;
  logic [31:0]   status;

  assign exec    = cmd_valid && room;
  assign cmd_pop = exec;

  assign factor  = (control_word[15:8] == 8'd0) ? FACTOR_DEFAULT : control_word[15:8];
  assign sum_inc = running_sum + 32'(cmd.density);
  assign cnt_inc = decimation_count + 8'd1;
  assign diff    = sum_inc - previous_sum;
  assign status  = {28'd0, watermark_bit, overrun_bit,
                    (fill_count >= FW'(FIFO_DEPTH)), (fill_count == '0)};

  always_comb begin
    running_sum_next      = running_sum;
    previous_sum_next     = previous_sum;
    decimation_count_next = decimation_count;
    read_pointer_next     = read_pointer;
    write_pointer_next    = write_pointer;
    fill_count_next       = fill_count;
    overrun_bit_next      = overrun_bit;
    watermark_bit_next    = watermark_bit;
    irq_state_next        = irq_state;
    eval                  = 1'b0;
    mem_we                = 1'b0;
    mem_re                = 1'b0;
    rdata                 = 32'd0;
    use_mem               = 1'b0;

    if (exec) begin
      unique case (cmd.op)
        OP_SAMPLE: begin
          if (control_word[0]) begin
            running_sum_next      = sum_inc;
            decimation_count_next = cnt_inc;
            if (cnt_inc >= factor) begin
              decimation_count_next = 8'd0;
              previous_sum_next     = sum_inc;
              eval                  = 1'b1;
              if (fill_count < FW'(FIFO_DEPTH)) begin
                mem_we             = 1'b1;
                write_pointer_next = (write_pointer == AW'(FIFO_DEPTH - 1)) ?
                                     '0 : write_pointer + AW'(1);
                fill_count_next    = fill_count + FW'(1);
              end else begin
                overrun_bit_next = 1'b1;
              end
            end
          end
        end
        OP_RD_CTRL: begin
          rdata = control_word;
          eval  = 1'b1;
        end
        OP_RD_STATUS: begin
          rdata = status;
          eval  = 1'b1;
        end
        OP_RD_DATA: begin
          eval = 1'b1;
          if (fill_count != '0) begin
            mem_re            = 1'b1;
            use_mem           = 1'b1;
            read_pointer_next = (read_pointer == AW'(FIFO_DEPTH - 1)) ?
                                '0 : read_pointer + AW'(1);
            fill_count_next   = fill_count - FW'(1);
            if (CMW'(fill_count_next) < CMW'(watermark_level)) begin
              watermark_bit_next = 1'b0;
            end
          end
        end
        OP_RD_WMARK: begin
          rdata = 32'(watermark_level);
          eval  = 1'b1;
        end
        OP_WR_REG: begin
          eval = 1'b1;
        end
        OP_WR_CLEAR: begin
          eval = 1'b1;
          if (cmd.clr[0]) begin
            overrun_bit_next = 1'b0;
          end
          if (cmd.clr[1]) begin
            watermark_bit_next = 1'b0;
          end
        end
        OP_ERR, OP_NOP: begin
        end
        default: begin
        end
      endcase

      if (eval) begin
        if (CMW'(fill_count_next) >= CMW'(watermark_level)) begin
          watermark_bit_next = 1'b1;
        end
        irq_state_next = control_word[1] && (watermark_bit_next || overrun_bit_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum      <= '0;
      previous_sum     <= '0;
      decimation_count <= '0;
      read_pointer     <= '0;
      write_pointer    <= '0;
      fill_count       <= '0;
      overrun_bit      <= 1'b0;
      watermark_bit    <= 1'b0;
      irq_state        <= 1'b0;
      b_valid          <= 1'b0;
    end else begin
      running_sum      <= running_sum_next;
      previous_sum     <= previous_sum_next;
      decimation_count <= decimation_count_next;
      read_pointer     <= read_pointer_next;
      write_pointer    <= write_pointer_next;
      fill_count       <= fill_count_next;
      overrun_bit      <= overrun_bit_next;
      watermark_bit    <= watermark_bit_next;
      irq_state        <= irq_state_next;
      b_valid          <= exec;
    end
  end

  always_ff @(posedge clk) begin
    b_rdata   <= rdata;
    b_use_mem <= use_mem;
    b_code    <= cmd.code;
    b_irq     <= irq_state_next;
  end

  // Sample memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_store[write_pointer] <= diff;
    end
    if (mem_re) begin
      mem_q <= sample_store[read_pointer];
    end
  end

  assign res_push           = b_valid;
  assign res_data.read_data = b_use_mem ? mem_q : b_rdata;
  assign res_data.code      = b_code;
  assign res_data.irq       = b_irq;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FW'(FIFO_DEPTH))
    else $error("sample FIFO fill exceeds its depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill_count == '0) |-> (read_pointer == write_pointer))
    else $error("empty sample FIFO with unequal pointers");

  a_overrun_full: assert property (@(posedge clk) disable iff (rst)
    $rose(overrun_bit) |-> $past(fill_count == FW'(FIFO_DEPTH)))
    else $error("overrun set while the sample FIFO had room");

  a_result_follows_exec: assert property (@(posedge clk) disable iff (rst)
    exec |=> b_valid)
    else $error("executed command produced no result");

endmodule
`default_nettype wire
